>>> design/nhle_pkg.sv
// nhle_pkg: constants, prefix tables and shared types for the name hash block
// used by nhle_hash, nhle_escape and name_hash_with_literal_escape_core
// no dependencies
`default_nettype none

package nhle_pkg;

    // hash constants
    localparam logic [31:0] HASH_BASIS    = 32'h4B9ACE2F;
    localparam logic [31:0] HASH_PRIME    = 32'h01000193;
    // prime squared modulo 2^32, folds the closing multiply into the last byte
    localparam logic [31:0] HASH_PRIME_SQ = 32'h26027A69;

    // escape constants
    localparam int PREFIX_COUNT   = 5;
    localparam int PREFIX_MAX_LEN = 9;
    localparam int LITERAL_DIGITS = 8;

    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

    // control that travels from the input stage to the working units
    typedef struct packed {
        logic step;      // the held item moves on this cycle
        logic has_char;  // the item carries a byte
        logic last;      // the item ends the name
    } nhle_step_t;

    // prefix character at a position, zero beyond the end
    function automatic logic [7:0] prefix_char(input logic [2:0] k, input logic [3:0] pos);
        logic [8*PREFIX_MAX_LEN-1:0] text;
        logic [8*PREFIX_MAX_LEN-1:0] shifted;
        unique case (k)
            3'd0:    text = {"hash", 40'd0};
            3'd1:    text = {"id", 56'd0};
            3'd2:    text = {"function", 8'd0};
            3'd3:    text = {"var", 48'd0};
            3'd4:    text = "namespace";
            default: text = '0;
        endcase
        shifted = text << {pos, 3'b000};
        return shifted[8*PREFIX_MAX_LEN-1 -: 8];
    endfunction

    // prefix length
    function automatic logic [3:0] prefix_len(input logic [2:0] k);
        logic [3:0] len;
        unique case (k)
            3'd0:    len = 4'd4;
            3'd1:    len = 4'd2;
            3'd2:    len = 4'd8;
            3'd3:    len = 4'd3;
            3'd4:    len = 4'd9;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    // hex digit decode: {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] ch);
        logic [4:0] res;
        if (ch >= "0" && ch <= "9") begin
            res = {1'b1, 4'(ch - 8'h30)};
        end else if (ch >= "a" && ch <= "f") begin
            res = {1'b1, 4'(ch - 8'h57)};
        end else if (ch >= "A" && ch <= "F") begin
            res = {1'b1, 4'(ch - 8'h37)};
        end else begin
            res = '0;
        end
        return res;
    endfunction

    // lower-case A to Z only
    function automatic logic [7:0] to_lower(input logic [7:0] ch);
        return (ch >= "A" && ch <= "Z") ? (ch | 8'h20) : ch;
    endfunction

endpackage

`default_nettype wire

>>> design/nhle_hash.sv
// nhle_hash: running fnv-1a style hash state (fnv prime, own basis) and the closing hash of a name
// depends on nhle_pkg
`default_nettype none

module nhle_hash
    import nhle_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire nhle_step_t  ctrl,
    input  wire logic [7:0]  char_code,
    output logic      [31:0] final_hash
);

    logic [31:0] hash_reg;
    logic [31:0] hash_next;
    logic [31:0] mixed;
    logic [31:0] stepped;

    // byte mixed in, one prime multiply
    assign mixed   = hash_reg ^ {24'd0, to_lower(char_code)};
    assign stepped = mixed * HASH_PRIME;

    // closing hash: closing multiply folded into the squared prime
    assign final_hash = ctrl.has_char ? mixed * HASH_PRIME_SQ : hash_reg * HASH_PRIME;

    // next running hash
    always_comb begin
        hash_next = hash_reg;
        if (ctrl.step) begin
            if (ctrl.last) begin
                hash_next = HASH_BASIS;
            end else if (ctrl.has_char) begin
                hash_next = stepped;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= HASH_BASIS;
        end else begin
            hash_reg <= hash_next;
        end
    end

endmodule

`default_nettype wire

>>> design/nhle_escape.sv
// nhle_escape: parser for the underscore, prefix and eight-hex-digit literal escape
// depends on nhle_pkg
`default_nettype none

module nhle_escape
    import nhle_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire nhle_step_t  ctrl,
    input  wire logic [7:0]  char_code,
    output logic             literal_hit,
    output logic      [31:0] literal_value
);

    typedef enum logic [3:0] {
        PH_START  = 4'b0001,
        PH_PREFIX = 4'b0010,
        PH_HEX    = 4'b0100,
        PH_FAIL   = 4'b1000
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [3:0]                pos_reg, pos_next;
    logic [PREFIX_COUNT-1:0]   cand_reg, cand_next;
    logic [31:0]               lit_reg, lit_next;
    logic [3:0]                cnt_reg, cnt_next;
    logic [PREFIX_COUNT-1:0]   cand_keep;
    logic [PREFIX_COUNT-1:0]   len_hit;
    logic [4:0]                digit;
    logic                      is_us;

    // per-prefix match of this byte and of a closing underscore
    always_comb begin
        for (int k = 0; k < PREFIX_COUNT; k++) begin
            len_hit[k]   = cand_reg[k] && (prefix_len(3'(k)) == pos_reg);
            cand_keep[k] = cand_reg[k] && (pos_reg < prefix_len(3'(k))) &&
                           (prefix_char(3'(k), pos_reg) == char_code);
        end
    end

    assign digit = hex_digit(char_code);
    assign is_us = (char_code == CHAR_UNDERSCORE);

    // parse step for one byte
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        cand_next  = cand_reg;
        lit_next   = lit_reg;
        cnt_next   = cnt_reg;
        if (ctrl.has_char) begin
            unique case (phase_reg)
                PH_START, PH_PREFIX: begin
                    if (is_us && phase_reg == PH_START) begin
                        phase_next = PH_PREFIX;
                    end else if (is_us) begin
                        phase_next = (|len_hit) ? PH_HEX : PH_FAIL;
                    end else begin
                        cand_next  = cand_keep;
                        pos_next   = (pos_reg == 4'd15) ? pos_reg : pos_reg + 4'd1;
                        phase_next = (|cand_keep) ? PH_PREFIX : PH_FAIL;
                    end
                end
                PH_HEX: begin
                    if (!digit[4]) begin
                        phase_next = PH_FAIL;
                    end else begin
                        if (cnt_reg < 4'(LITERAL_DIGITS)) begin
                            lit_next = {lit_reg[27:0], digit[3:0]};
                        end
                        if (cnt_reg < 4'(LITERAL_DIGITS + 1)) begin
                            cnt_next = cnt_reg + 4'd1;
                        end
                    end
                end
                PH_FAIL: begin
                    phase_next = PH_FAIL;
                end
                default: begin
                    phase_next = PH_FAIL;
                end
            endcase
        end
    end

    // escape taken when exactly eight digits give a nonzero value
    assign literal_hit   = (phase_next == PH_HEX) && (cnt_next == 4'(LITERAL_DIGITS)) &&
                           (lit_next != 32'd0);
    assign literal_value = lit_next;

    // parser state, back to start after each name
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            pos_reg   <= '0;
            cand_reg  <= '1;
            lit_reg   <= '0;
            cnt_reg   <= '0;
        end else if (ctrl.step) begin
            if (ctrl.last) begin
                phase_reg <= PH_START;
                pos_reg   <= '0;
                cand_reg  <= '1;
                lit_reg   <= '0;
                cnt_reg   <= '0;
            end else begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                cand_reg  <= cand_next;
                lit_reg   <= lit_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/name_hash_with_literal_escape_core.sv
// name_hash_with_literal_escape_core: top level of the name hash block
// depends on nhle_pkg, nhle_hash, nhle_escape
//
//  channel | direction | ports                                        | meaning
//  s_      | in        | s_valid s_ready s_char_code s_end_of_name    | one byte of a name
//          |           | s_no_char                                    |
//  m_      | out       | m_valid m_ready m_hash_value m_used_literal  | hash of a name
//
// one item per cycle, except while an ending item waits for the result register; a name's
// hash leaves through the input register, then the result register
// the hash and escape state update in one pass per held item
// aresetn is synchronous, active low, and clears the hash and parser state
// while a result waits, bytes that do not end a name keep flowing; an ending
// item waits in the input register until the result register frees
`default_nettype none

module name_hash_with_literal_escape_core
    import nhle_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_code,
    input  wire logic        s_end_of_name,
    input  wire logic        s_no_char,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [31:0] m_hash_value,
    output logic             m_used_literal
);

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_last_reg;
    logic        in_none_reg;
    logic        out_valid_reg;
    logic [31:0] out_hash_reg;
    logic        out_lit_reg;
    logic        advance;
    nhle_step_t  ctrl;
    logic [31:0] final_hash;
    logic        literal_hit;
    logic [31:0] literal_value;

    // held item moves unless it ends a name and the result register is full
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign ctrl.step     = advance;
    assign ctrl.has_char = !in_none_reg;
    assign ctrl.last     = in_last_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_code;
            in_last_reg <= s_end_of_name;
            in_none_reg <= s_no_char;
        end
    end

    nhle_hash u_hash (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .char_code  (in_char_reg),
        .final_hash (final_hash)
    );

    nhle_escape u_escape (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .char_code     (in_char_reg),
        .literal_hit   (literal_hit),
        .literal_value (literal_value)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_hash_reg <= literal_hit ? literal_value : final_hash;
            out_lit_reg  <= literal_hit;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_hash_value   = out_hash_reg;
    assign m_used_literal = out_lit_reg;

endmodule

`default_nettype wire

>>> design/nhle_checker.sv
// nhle_checker: port-level assertions for the name hash block, bound to the top level
// depends on name_hash_with_literal_escape_core
`default_nettype none

module nhle_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_end_of_name,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_hash_value,
    input wire logic        m_used_literal
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hash_value) && $stable(m_used_literal))
        else $error("result changed while stalled");

    // a returned literal is never zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_used_literal |-> m_hash_value != 32'd0)
        else $error("zero literal returned");

    // an ending item leads to a valid result once it has passed the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_end_of_name |-> ##2 m_valid)
        else $error("result missing after end of name");

    // input stalls only behind a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with result side free");

endmodule

bind name_hash_with_literal_escape_core nhle_checker u_nhle_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_end_of_name  (s_end_of_name),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_hash_value   (m_hash_value),
    .m_used_literal (m_used_literal)
);

`default_nettype wire

>>> verif/tb_name_hash_with_literal_escape_core.sv
// tb_name_hash_with_literal_escape_core: self-checking bench for the name hash block
// drives names byte by byte, predicts each hash or literal escape and checks every result
// depends on name_hash_with_literal_escape_core and the files under design/

module tb_name_hash_with_literal_escape_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] NAME_BASIS      = 32'h4B9ACE2F;
    localparam logic [31:0] NAME_PRIME      = 32'h01000193;
    // basis times prime, the hash of a name with no bytes
    localparam logic [31:0] EMPTY_NAME_HASH = 32'h33B293FD;
    localparam int          RANDOM_ITEMS    = 500;
    localparam int          HOLD_CYCLES     = 80;
    localparam int          STALL_LIMIT     = 1000;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int          REPORT_LIMIT    = 10;

    typedef enum logic [1:0] {
        PH_START,
        PH_PREFIX,
        PH_HEX,
        PH_FAIL
    } escape_phase_t;

    // one item on the input channel, with an optional pinned result for directed rows
    typedef struct packed {
        logic [7:0]  ch;
        logic        eon;
        logic        nc;
        logic        pin;
        logic [31:0] pin_hash;
        logic        pin_lit;
    } name_item_t;

    typedef struct packed {
        logic [31:0] hash;
        logic        lit;
    } name_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_char_code;
    logic        s_end_of_name;
    logic        s_no_char;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_hash_value;
    logic        m_used_literal;

    // pinned expectation travelling with the item on the wire
    logic        cur_pin;
    logic [31:0] cur_pin_hash;
    logic        cur_pin_lit;

    // predictor state
    logic [31:0]   name_hash_acc;
    escape_phase_t esc_phase;
    logic [3:0]    pfx_pos;
    logic [4:0]    pfx_live;
    logic [31:0]   lit_acc;
    logic [3:0]    hex_cnt;

    name_result_t hash_results_q[$];
    name_item_t   directed_q[$];
    name_item_t   name_items_q[$];
    name_item_t   seen_item;
    name_result_t head_result;

    int  mismatch_count = 0;
    int  idle_cycles = 0;
    int  tx_quiet_left = 0;
    bit  hold_req = 1'b0;

    name_hash_with_literal_escape_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .s_end_of_name  (s_end_of_name),
        .s_no_char      (s_no_char),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hash_value   (m_hash_value),
        .m_used_literal (m_used_literal)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // escape prefixes, case sensitive
    function automatic string pfx_name(input int k);
        case (k)
            0:       return "hash";
            1:       return "id";
            2:       return "function";
            3:       return "var";
            default: return "namespace";
        endcase
    endfunction

    // hex digit value, or -1 for anything else
    function automatic int hex_val(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9") return int'(ch) - 48;
        if (ch >= "a" && ch <= "f") return int'(ch) - 87;
        if (ch >= "A" && ch <= "F") return int'(ch) - 55;
        return -1;
    endfunction

    function automatic void clear_name_state();
        name_hash_acc = NAME_BASIS;
        esc_phase     = PH_START;
        pfx_pos       = 4'd0;
        pfx_live      = 5'h1F;
        lit_acc       = 32'd0;
        hex_cnt       = 4'd0;
    endfunction

    // one byte while a prefix is being matched
    function automatic void prefix_step(input logic [7:0] ch);
        string      w;
        logic [4:0] next_live;
        logic       ends_here;
        next_live = 5'd0;
        ends_here = 1'b0;
        for (int k = 0; k < 5; k++) begin
            w = pfx_name(k);
            if (pfx_live[k]) begin
                if (ch == "_" && int'(pfx_pos) == w.len()) ends_here = 1'b1;
                if (ch != "_" && int'(pfx_pos) < w.len() && w[pfx_pos] == ch)
                    next_live[k] = 1'b1;
            end
        end
        if (ch == "_") begin
            esc_phase = ends_here ? PH_HEX : PH_FAIL;
        end else begin
            pfx_live = next_live;
            if (pfx_pos != 4'hF) pfx_pos = pfx_pos + 4'd1;
            esc_phase = (next_live != 5'd0) ? PH_PREFIX : PH_FAIL;
        end
    endfunction

    // escape parser, one byte
    function automatic void escape_step(input logic [7:0] ch);
        int d;
        case (esc_phase)
            PH_START: begin
                if (ch == "_") esc_phase = PH_PREFIX;
                else prefix_step(ch);
            end
            PH_PREFIX: prefix_step(ch);
            PH_HEX: begin
                d = hex_val(ch);
                if (d < 0) begin
                    esc_phase = PH_FAIL;
                end else begin
                    if (hex_cnt < 4'd8) lit_acc = {lit_acc[27:0], 4'(d)};
                    if (hex_cnt < 4'd9) hex_cnt = hex_cnt + 4'd1;
                end
            end
            default: esc_phase = PH_FAIL;
        endcase
    endfunction

    // fold an accepted item into the hash and queue the result when the name ends
    function automatic void fold_name_item(input name_item_t it);
        logic [7:0]   low;
        name_result_t res;
        if (!it.nc) begin
            low = (it.ch >= "A" && it.ch <= "Z") ? it.ch + 8'd32 : it.ch;
            name_hash_acc = (name_hash_acc ^ {24'd0, low}) * NAME_PRIME;
            escape_step(it.ch);
        end
        if (it.eon) begin
            if (esc_phase == PH_HEX && hex_cnt == 4'd8 && lit_acc != 32'd0) begin
                res.hash = lit_acc;
                res.lit  = 1'b1;
            end else begin
                res.hash = name_hash_acc * NAME_PRIME;
                res.lit  = 1'b0;
            end
            if (it.pin) begin
                res.hash = it.pin_hash;
                res.lit  = it.pin_lit;
            end
            hash_results_q.insert(hash_results_q.size(), res);
            clear_name_state();
        end
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch on %s: expected %h, got %h", what, want_v, got_v);
    endtask

    task automatic add_row(input logic [7:0] ch, input logic eon, input logic nc,
                           input logic pin, input logic [31:0] pin_hash, input logic pin_lit);
        name_item_t r;
        r.ch       = ch;
        r.eon      = eon;
        r.nc       = nc;
        r.pin      = pin;
        r.pin_hash = pin_hash;
        r.pin_lit  = pin_lit;
        directed_q.insert(directed_q.size(), r);
    endtask

    // a whole name as rows, the pinned result on the last byte
    task automatic add_text(input string s, input logic pin, input logic [31:0] pin_hash,
                            input logic pin_lit);
        for (int i = 0; i < s.len(); i++)
            add_row(s[i], i == s.len() - 1, 1'b0, pin, pin_hash, pin_lit);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
    endfunction

    task automatic push_item(input logic [7:0] ch, input logic eon, input logic nc);
        name_item_t r;
        r          = '0;
        r.ch       = ch;
        r.eon      = eon;
        r.nc       = nc;
        name_items_q.insert(name_items_q.size(), r);
    endtask

    // one random name: mostly escapes with random content, some broken, some noise
    task automatic make_random_name();
        logic [7:0]  bytes[$];
        logic [31:0] lit;
        string       w;
        int          kind;
        int          n;
        int          idx;
        bit          sep_end;
        kind = $urandom_range(0, 99);
        if (kind < 5) begin
            // empty name
        end else if (kind < 60) begin
            if ($urandom_range(0, 1)) bytes.insert(bytes.size(), "_");
            w = pfx_name($urandom_range(0, 4));
            for (int i = 0; i < w.len(); i++) bytes.insert(bytes.size(), w[i]);
            bytes.insert(bytes.size(), "_");
            case ($urandom_range(0, 9))
                0:       lit = 32'd0;
                1:       lit = 32'hFFFF_FFFF;
                2:       lit = 32'd1;
                default: lit = $urandom();
            endcase
            for (int i = 0; i < 8; i++)
                bytes.insert(bytes.size(), hex_char(lit[31 - 4*i -: 4]));
            // damage a quarter of the escapes
            if ($urandom_range(0, 3) == 0) begin
                idx = $urandom_range(0, bytes.size() - 1);
                case ($urandom_range(0, 5))
                    0: bytes.delete(bytes.size() - 1);
                    1: bytes.insert(bytes.size(), hex_char(4'($urandom_range(0, 15))));
                    2: bytes.push_front("_");
                    3: bytes[idx] = bytes[idx] ^ 8'h20;
                    4: bytes[idx] = 8'($urandom_range(0, 255));
                    default: bytes.delete(idx);
                endcase
            end
        end else if (kind < 75) begin
            // part of a prefix, then a short tail
            w = pfx_name($urandom_range(0, 4));
            n = $urandom_range(0, w.len());
            for (int i = 0; i < n; i++) bytes.insert(bytes.size(), w[i]);
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 2))
                    0:       bytes.insert(bytes.size(), "_");
                    1:       bytes.insert(bytes.size(), hex_char(4'($urandom_range(0, 15))));
                    default: bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
                endcase
            end
        end else begin
            // arbitrary bytes, upper case letters favoured
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 2) == 0)
                    bytes.insert(bytes.size(), 8'($urandom_range(65, 90)));
                else
                    bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
            end
        end

        // byte-less items sprinkled in, and sometimes a separate closing item
        sep_end = ($urandom_range(0, 9) == 0) || (bytes.size() == 0);
        for (int i = 0; i < bytes.size(); i++) begin
            if ($urandom_range(0, 19) == 0) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            push_item(bytes[i], (i == bytes.size() - 1) && !sep_end, 1'b0);
        end
        if (sep_end) push_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endtask

    // offer one item after a random gap and wait until it is taken
    task automatic send_item(input name_item_t it);
        int gap;
        if (tx_quiet_left > 0) begin
            gap = 0;
            tx_quiet_left--;
        end else begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 24) == 0) tx_quiet_left = $urandom_range(10, 30);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_char_code   <= it.ch;
        s_end_of_name <= it.eon;
        s_no_char     <= it.nc;
        cur_pin       <= it.pin;
        cur_pin_hash  <= it.pin_hash;
        cur_pin_lit   <= it.pin_lit;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // input side: every accepted item goes through the predictor
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && s_valid && s_ready === 1'b1) begin
            seen_item.ch       = s_char_code;
            seen_item.eon      = s_end_of_name;
            seen_item.nc       = s_no_char;
            seen_item.pin      = cur_pin;
            seen_item.pin_hash = cur_pin_hash;
            seen_item.pin_lit  = cur_pin_lit;
            fold_name_item(seen_item);
        end
    end

    // result side: compare against the oldest expected hash
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready) begin
            if (hash_results_q.size() == 0) begin
                note_mismatch("result with none expected", 32'd0, m_hash_value);
            end else begin
                head_result = hash_results_q.pop_front();
                if (m_hash_value !== head_result.hash)
                    note_mismatch("hash_value", head_result.hash, m_hash_value);
                if (m_used_literal !== head_result.lit)
                    note_mismatch("used_literal", {31'd0, head_result.lit},
                                  {31'd0, m_used_literal});
            end
        end
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // result sink with random stalls, quiet runs and one long hold-off
    initial begin : result_sink
        int stall;
        int rx_quiet_left;
        bit hold_done;
        rx_quiet_left = 0;
        hold_done     = 1'b0;
        m_ready       = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (rx_quiet_left > 0) begin
                stall = 0;
                rx_quiet_left--;
            end else begin
                stall = $urandom_range(0, 8);
                if ($urandom_range(0, 7) == 0) rx_quiet_left = $urandom_range(5, 15);
            end
            if (hold_req && !hold_done) begin
                stall     = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready));
        end
    end

    // reset, directed table, random names, drain
    initial begin : stimulus
        name_item_t row;
        int         sent;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_char_code   = 8'd0;
        s_end_of_name = 1'b0;
        s_no_char     = 1'b0;
        cur_pin       = 1'b0;
        cur_pin_hash  = 32'd0;
        cur_pin_lit   = 1'b0;
        clear_name_state();

        // empty name straight after reset
        add_row(8'h00, 1'b1, 1'b1, 1'b1, EMPTY_NAME_HASH, 1'b0);
        // leading underscore, mixed case digits, largest literal
        add_text("_id_FfFfFfFf", 1'b1, 32'hFFFF_FFFF, 1'b1);
        // byte extremes with a byte-less item in the middle
        add_row(8'h00, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0);
        add_row(8'hA5, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0);
        add_row(8'hFF, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0);
        // second leading underscore rules the escape out
        add_text("__id_1", 1'b0, 32'd0, 1'b0);
        // upper case folding
        add_text("Z", 1'b0, 32'd0, 1'b0);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_q[i]) send_item(directed_q[i]);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // long hold-off on the result side while items keep coming
            if (!hold_req && sent >= RANDOM_ITEMS / 3) begin
                hold_req      = 1'b1;
                tx_quiet_left = 60;
            end
            make_random_name();
            while (name_items_q.size() != 0) begin
                row = name_items_q.pop_front();
                send_item(row);
                if (!row.nc || row.eon) sent++;
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (hash_results_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
design/nhle_pkg.sv
design/nhle_hash.sv
design/nhle_escape.sv
design/name_hash_with_literal_escape_core.sv
design/nhle_checker.sv
verif/tb_name_hash_with_literal_escape_core.sv
